FILE: src/motion_profile_generator_defines.svh
// Assertion macros for the motion profile generator.
`ifndef MOTION_PROFILE_GENERATOR_DEFINES_SVH
`define MOTION_PROFILE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define MPG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpg: same-cycle check failed");
`define MPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpg: next-cycle check failed");
`else
`define MPG_ASSERT_SAME(lbl, ante, cons)
`define MPG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/mpg_pkg.sv
package mpg_pkg;

  localparam int VAL_W   = 32;
  localparam int FUNC_W  = 2;
  localparam int DT_W    = 24;
  localparam int REG_W   = 31;
  localparam int DT_FRAC = 24;

  localparam logic [31:0] TOL_DEFAULT = 32'd66;
  localparam logic [23:0] DT_EPS      = 24'd16;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_TARGET = 2'd1;
  localparam logic [1:0] FUNC_RESET  = 2'd2;
  localparam logic [1:0] FUNC_RATE   = 2'd3;

  localparam logic [1:0] MODE_OFF        = 2'd0;
  localparam logic [1:0] MODE_TRAP       = 2'd1;
  localparam logic [1:0] MODE_SCURVE     = 2'd2;
  localparam logic [1:0] MODE_SCURVE_ALT = 2'd3;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_RATE  = 3'd1;
  localparam logic [2:0] REG_ACCEL = 3'd2;
  localparam logic [2:0] REG_JERK  = 3'd3;
  localparam logic [2:0] REG_TOL   = 3'd4;

  typedef logic signed [VAL_W-1:0] val_t;

endpackage

FILE: src/mpg_if.sv
interface mpg_in_if import mpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  val_t              value_in;
  logic [DT_W-1:0]   time_step;

  modport source (output valid, func, value_in, time_step, input ready);
  modport sink   (input valid, func, value_in, time_step, output ready);
endinterface

interface mpg_out_if import mpg_pkg::*; ();
  logic valid;
  logic ready;
  val_t planned_value;
  val_t planned_rate;
  logic arrived;
  logic moving;

  modport source (output valid, planned_value, planned_rate, arrived, moving, input ready);
  modport sink   (input valid, planned_value, planned_rate, arrived, moving, output ready);
endinterface

FILE: src/motion_profile_generator.sv
// Motion profile generator: each command (tick, set target, reset to value, set rate) yields
// one result. For non-tick commands and ticks in passthrough mode the result is registered
// directly at transfer. A profiled tick runs a sequencer around one shared 34x34 multiplier
// and one shift-subtract unit: trapezoidal mode steps through the squaring, compare, rate
// and position states, adding a square-root rate limit when inside the braking distance;
// S-curve mode adds acceleration states, plus bit-serial division when dt exceeds 16 LSB.
// The block takes a new command in the cycle after the previous result has been transferred.
`include "motion_profile_generator_defines.svh"

module motion_profile_generator import mpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mpg_in_if.sink      in_ch,
  mpg_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RSQ   = 4'd1;
  localparam logic [3:0] S_DSQ   = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_RATE  = 4'd5;
  localparam logic [3:0] S_TRAP  = 4'd6;
  localparam logic [3:0] S_DIVST = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_ACC   = 4'd9;
  localparam logic [3:0] S_AMUL  = 4'd10;
  localparam logic [3:0] S_ARATE = 4'd11;
  localparam logic [3:0] S_POS   = 4'd12;
  localparam logic [3:0] S_VAL   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  localparam logic signed [69:0] SAT_MAX = 70'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [69:0] SAT_MIN = -SAT_MAX - 70'sd1;

  function automatic val_t sat(input logic signed [69:0] x);
    if (x > SAT_MAX) return val_t'(SAT_MAX);
    if (x < SAT_MIN) return val_t'(SAT_MIN);
    return x[31:0];
  endfunction

  function automatic logic signed [34:0] slew(input logic signed [34:0] d,
                                              input logic [30:0] s);
    logic [34:0] mag;
    mag = d[34] ? 35'(-d) : 35'(d);
    if (mag > {4'd0, s}) return d[34] ? -$signed({4'd0, s}) : $signed({4'd0, s});
    return d;
  endfunction

  logic [3:0]  state_r;
  logic [1:0]  mode_r;
  logic [30:0] max_rate_r, max_accel_r, max_jerk_r, tol_r;
  val_t        goal_r, pos_r, rate_r, accel_r;
  logic        busy_r;
  logic [23:0] dt_r;
  logic signed [67:0] prod_r;
  logic [63:0] rsq_r;
  logic [31:0] limit_r;
  logic [30:0] astep_r;
  val_t        ta_r;
  logic        neg_r, div_mode_r;
  logic [34:0] rem_r;
  logic [57:0] quo_r;
  logic [63:0] rad_r;
  logic [5:0]  cnt_r;
  logic        out_valid_r, out_arrived_r, out_moving_r;
  val_t        out_value_r, out_rate_r;

  // Error, distance and target rate from stored state
  logic signed [32:0] err;
  logic [32:0]        dist_abs;
  logic [31:0]        ra;
  logic signed [33:0] trate;
  logic signed [34:0] rerr;
  logic [32:0]        rerr_mag;

  assign err      = 33'(goal_r) - 33'(pos_r);
  assign dist_abs = err[32] ? 33'(-err) : 33'(err);
  assign ra       = rate_r[31] ? 32'(-rate_r) : 32'(rate_r);
  assign trate    = err[32] ? -$signed({2'b00, limit_r}) :
                    (err == 33'sd0) ? 34'sd0 : $signed({2'b00, limit_r});
  assign rerr     = 35'(trate) - 35'(rate_r);
  assign rerr_mag = rerr[34] ? 33'(-rerr) : 33'(rerr);

  // Shared multiplier
  logic signed [33:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_RSQ: begin
        mul_a = $signed({2'b00, ra});
        mul_b = $signed({2'b00, ra});
      end
      S_DSQ: begin
        mul_a = $signed({2'b00, max_accel_r, 1'b0});
        mul_b = $signed({1'b0, dist_abs});
      end
      S_RATE: begin
        mul_a = $signed({3'b000, (mode_r == MODE_TRAP) ? max_accel_r : max_jerk_r});
        mul_b = $signed({10'd0, dt_r});
      end
      S_AMUL: begin
        mul_a = 34'(accel_r);
        mul_b = $signed({10'd0, dt_r});
      end
      S_POS: begin
        mul_a = 34'(rate_r);
        mul_b = $signed({10'd0, dt_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared shift-subtract unit: restoring division or digit-by-digit square root
  logic [34:0] rem_sh, sub_op;
  logic [35:0] trial;
  logic        trial_ok;
  assign rem_sh   = div_mode_r ? {rem_r[33:0], rad_r[57]} : {rem_r[32:0], rad_r[63:62]};
  assign sub_op   = div_mode_r ? {11'd0, dt_r} : {1'b0, quo_r[31:0], 2'b01};
  assign trial    = {1'b0, rem_sh} - {1'b0, sub_op};
  assign trial_ok = !trial[35];

  logic [57:0] quo_fin;
  logic [31:0] ta_mag;
  assign quo_fin = {quo_r[56:0], trial_ok};
  assign ta_mag  = (quo_fin > {27'd0, max_accel_r}) ? {1'b0, max_accel_r} : quo_fin[31:0];

  logic near;
  assign near = (max_accel_r == '0) ? (dist_abs == '0) : (prod_r[65:0] <= {2'b00, rsq_r});

  logic [30:0]  tol;
  logic [32:0]  tgt_diff, tgt_mag;
  val_t         new_pos;
  logic         arrive;
  assign tol      = (tol_r != '0) ? tol_r : TOL_DEFAULT[30:0];
  assign tgt_diff = 33'(in_ch.value_in) - 33'(pos_r);
  assign tgt_mag  = tgt_diff[32] ? 33'(-$signed(tgt_diff)) : tgt_diff;
  assign new_pos  = sat(70'(pos_r) + 70'(prod_r >>> DT_FRAC));
  assign arrive   = (dist_abs <= {2'b00, tol}) && (ra <= {1'b0, tol});

  logic in_xfer, out_xfer, cfg_wr;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[4:2])
      REG_MODE:  cfg_prdata = {30'd0, mode_r};
      REG_RATE:  cfg_prdata = {1'b0, max_rate_r};
      REG_ACCEL: cfg_prdata = {1'b0, max_accel_r};
      REG_JERK:  cfg_prdata = {1'b0, max_jerk_r};
      REG_TOL:   cfg_prdata = {1'b0, tol_r};
      default:   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= '0;
      max_rate_r  <= '0;
      max_accel_r <= '0;
      max_jerk_r  <= '0;
      tol_r       <= '0;
      goal_r      <= '0;
      pos_r       <= '0;
      rate_r      <= '0;
      accel_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          REG_MODE:  mode_r      <= cfg_pwdata[1:0];
          REG_RATE:  max_rate_r  <= cfg_pwdata[30:0];
          REG_ACCEL: max_accel_r <= cfg_pwdata[30:0];
          REG_JERK:  max_jerk_r  <= cfg_pwdata[30:0];
          REG_TOL:   tol_r       <= cfg_pwdata[30:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            dt_r          <= in_ch.time_step;
            out_value_r   <= pos_r;
            out_rate_r    <= rate_r;
            out_moving_r  <= busy_r;
            out_arrived_r <= (mode_r == MODE_OFF) || !busy_r;
            state_r       <= S_OUT;
            out_valid_r   <= 1'b1;
            case (in_ch.func)
              FUNC_TARGET: begin
                goal_r        <= in_ch.value_in;
                busy_r        <= (tgt_mag > {1'b0, TOL_DEFAULT});
                out_moving_r  <= (tgt_mag > {1'b0, TOL_DEFAULT});
                out_arrived_r <= (mode_r == MODE_OFF) || !(tgt_mag > {1'b0, TOL_DEFAULT});
              end
              FUNC_RESET: begin
                goal_r        <= in_ch.value_in;
                pos_r         <= in_ch.value_in;
                rate_r        <= '0;
                accel_r       <= '0;
                busy_r        <= 1'b0;
                out_value_r   <= in_ch.value_in;
                out_rate_r    <= '0;
                out_arrived_r <= 1'b1;
                out_moving_r  <= 1'b0;
              end
              FUNC_RATE: begin
                rate_r     <= in_ch.value_in;
                out_rate_r <= in_ch.value_in;
              end
              default: begin
                if (mode_r == MODE_OFF) begin
                  out_value_r   <= goal_r;
                  out_rate_r    <= '0;
                  out_arrived_r <= 1'b1;
                end else begin
                  // profiled tick: hold the result until the sequence ends
                  out_valid_r <= 1'b0;
                  state_r     <= S_RSQ;
                end
              end
            endcase
          end
        end
        S_RSQ: state_r <= S_DSQ;
        S_DSQ: begin
          rsq_r   <= prod_r[63:0];
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (near && (max_accel_r != '0)) begin
            rad_r      <= prod_r[63:0];
            rem_r      <= '0;
            quo_r      <= '0;
            div_mode_r <= 1'b0;
            cnt_r      <= 6'd31;
            state_r    <= S_SQRT;
          end else begin
            limit_r <= near ? 32'd0 : {1'b0, max_rate_r};
            state_r <= S_RATE;
          end
        end
        S_SQRT, S_DIV: begin
          rem_r <= trial_ok ? trial[34:0] : rem_sh;
          quo_r <= quo_fin;
          rad_r <= div_mode_r ? {rad_r[62:0], 1'b0} : {rad_r[61:0], 2'b00};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == '0) begin
            if (div_mode_r) begin
              ta_r    <= neg_r ? val_t'(-$signed(ta_mag)) : val_t'(ta_mag);
              state_r <= S_ACC;
            end else begin
              limit_r <= quo_fin[31:0];
              state_r <= S_RATE;
            end
          end
        end
        S_RATE: state_r <= (mode_r == MODE_TRAP) ? S_TRAP : S_DIVST;
        S_TRAP: begin
          rate_r  <= sat(70'(rate_r) + 70'(slew(rerr, prod_r[54:24])));
          state_r <= S_POS;
        end
        S_DIVST: begin
          astep_r <= prod_r[54:24];
          if (dt_r > DT_EPS) begin
            rad_r      <= {6'd0, 1'b0, rerr_mag, 24'd0};
            rem_r      <= '0;
            quo_r      <= '0;
            neg_r      <= rerr[34];
            div_mode_r <= 1'b1;
            cnt_r      <= 6'd57;
            state_r    <= S_DIV;
          end else begin
            ta_r    <= '0;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          accel_r <= sat(70'(accel_r) + 70'(slew(35'(ta_r) - 35'(accel_r), astep_r)));
          state_r <= S_AMUL;
        end
        S_AMUL: state_r <= S_ARATE;
        S_ARATE: begin
          rate_r  <= sat(70'(rate_r) + 70'(prod_r >>> DT_FRAC));
          state_r <= S_POS;
        end
        S_POS: state_r <= S_VAL;
        S_VAL: begin
          out_value_r   <= new_pos;
          out_rate_r    <= rate_r;
          out_arrived_r <= arrive;
          out_moving_r  <= !arrive;
          out_valid_r   <= 1'b1;
          state_r       <= S_OUT;
          if (arrive) begin
            // snap to the goal
            pos_r   <= goal_r;
            rate_r  <= '0;
            accel_r <= '0;
            busy_r  <= 1'b0;
          end else begin
            pos_r  <= new_pos;
            busy_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.planned_value = out_value_r;
  assign out_ch.planned_rate  = out_rate_r;
  assign out_ch.arrived       = out_arrived_r;
  assign out_ch.moving        = out_moving_r;

  `MPG_ASSERT_SAME(a_no_accept_with_result, out_valid_r, !in_ch.ready)
  `MPG_ASSERT_NEXT(a_busy_after_accept, in_xfer, !in_ch.ready)
  `MPG_ASSERT_NEXT(a_idle_after_result, out_xfer, in_ch.ready && !out_valid_r)
  `MPG_ASSERT_SAME(a_out_flags, out_valid_r && out_moving_r, !out_arrived_r || (mode_r == MODE_OFF))

endmodule
